/* rtl/gpc_pkg.sv */
// gpc_pkg: shared types and constants of the grid path counter.
// Used by gpc_count and grid_path_counter; depends on nothing else.
package gpc_pkg;

  // result word width and saturation value
  localparam int unsigned COUNT_W   = 12;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

  // reset value of both dimension registers
  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

  // input word layout
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  // counting sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } gpc_state_t;

  // status from the counting unit to the top level
  typedef struct packed {
    logic busy;   // a count is in progress or waiting to be delivered
    logic done;   // result valid this cycle and taken by the output register
  } gpc_status_t;

endpackage

/* rtl/gpc_count.sv */
// gpc_count: path counter that sweeps the grid one cell per cycle through a
// single saturating adder, keeping one row of partial counts.
// Depends on gpc_pkg.
module gpc_count #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic                                       take,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] rows_last,
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] cols_last,
  input  logic [MAX_COLS-1:0]                        row_bits,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] row_sel,
  output gpc_pkg::gpc_status_t                       status,
  output logic [gpc_pkg::COUNT_W-1:0]                count
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  gpc_pkg::gpc_state_t state_r, state_nxt;

  logic [RW-1:0]                r_r;
  logic [CW-1:0]                c_r;
  logic [gpc_pkg::COUNT_W-1:0]  left_r;
  logic [gpc_pkg::COUNT_W-1:0]  ways_r [MAX_COLS];
  logic [gpc_pkg::COUNT_W-1:0]  count_r;

  logic                         walk_en;
  logic                         last_col;
  logic                         last_cell;
  logic [gpc_pkg::COUNT_W-1:0]  up_val;
  logic [gpc_pkg::COUNT_W-1:0]  left_val;
  logic [gpc_pkg::COUNT_W:0]    sum;
  logic [gpc_pkg::COUNT_W-1:0]  cell_val;

  assign last_col  = (c_r == cols_last);
  assign last_cell = last_col && (r_r == rows_last);

  // shared adder: paths into this cell = from above + from the left
  assign up_val   = (r_r != '0) ? ways_r[c_r] : '0;
  assign left_val = (c_r != '0) ? left_r : '0;
  assign sum      = {1'b0, up_val} + {1'b0, left_val};

  always_comb begin
    if (row_bits[c_r]) begin
      cell_val = '0;
    end else if ((r_r == '0) && (c_r == '0)) begin
      cell_val = gpc_pkg::COUNT_W'(1);
    end else if (sum > {1'b0, gpc_pkg::COUNT_MAX}) begin
      cell_val = gpc_pkg::COUNT_MAX;
    end else begin
      cell_val = sum[gpc_pkg::COUNT_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gpc_pkg::ST_IDLE: if (start) state_nxt = gpc_pkg::ST_WALK;
      gpc_pkg::ST_WALK: if (last_cell) state_nxt = gpc_pkg::ST_DONE;
      gpc_pkg::ST_DONE: if (take) state_nxt = gpc_pkg::ST_IDLE;
      default:          state_nxt = gpc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    walk_en     = 1'b0;
    status.busy = 1'b1;
    status.done = 1'b0;
    unique case (state_r)
      gpc_pkg::ST_IDLE: status.busy = 1'b0;
      gpc_pkg::ST_WALK: walk_en = 1'b1;
      gpc_pkg::ST_DONE: status.done = take;
      default:          status.busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpc_pkg::ST_IDLE;
      r_r     <= '0;
      c_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (walk_en) begin
        if (last_col) begin
          c_r <= '0;
          r_r <= last_cell ? '0 : r_r + RW'(1);
        end else begin
          c_r <= c_r + CW'(1);
        end
      end
    end
  end

  // row of partial counts and the running result
  always_ff @(posedge clk) begin
    if (walk_en) begin
      ways_r[c_r] <= cell_val;
      left_r      <= cell_val;
      if (last_cell) count_r <= cell_val;
    end
  end

  assign row_sel = r_r;
  assign count   = count_r;

endmodule

/* rtl/grid_path_counter.sv */
// grid_path_counter: top level; grid bit store, dimension registers, stream
// handshakes and the result register. Depends on gpc_pkg and gpc_count.
//
// Usage:
//   The in_ stream carries one grid cell per word: row, column and blocked
//   flag in in_tdata, in_tlast set on the final cell. A word with in_tlast
//   stores its cell and then counts the right/down paths from the top-left
//   to the bottom-right cell of the area set by row_count and col_count,
//   avoiding blocked cells.
//   The cfg_ port writes row_count (index 0) and col_count (index 1); it is
//   always ready. Values of 0 act as 1, values above the store size saturate.
//   After a last word the count sweeps the area one cell per cycle through
//   one saturating adder, in the row loop and column loop of the sequencer;
//   the result is registered in the counter and then in the out_ register.
//   in_tready is low while a count runs or its result waits for the output
//   register. A finished result waits in that register while out_tready is
//   low; new load words are accepted meanwhile.
//   Reset clears the control state and sets both dimensions to 8; the grid
//   store is undefined until written.
module grid_path_counter #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gpc_pkg::IN_DATA_W-1:0]      in_tdata,  // cell_row[2:0], cell_col[5:3],
                                                        // cell_blocked[6], zero[7]
  input  logic                               in_tlast,  // last_cell
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gpc_pkg::OUT_DATA_W-1:0]     out_tdata, // path_count[11:0], zero[15:12]
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [gpc_pkg::CFG_DATA_W-1:0] row_count_r;
  logic [gpc_pkg::CFG_DATA_W-1:0] col_count_r;
  logic [MAX_COLS-1:0]            blocked_rows_r [MAX_ROWS];
  logic                           out_valid_r;
  logic [gpc_pkg::COUNT_W-1:0]    out_data_r;

  logic [2:0]                     cell_row;
  logic [2:0]                     cell_col;
  logic                           cell_blocked;
  logic                           in_fire;
  logic                           in_store;
  logic [RW-1:0]                  rows_last;
  logic [CW-1:0]                  cols_last;
  logic [RW-1:0]                  row_sel;
  logic                           take;
  gpc_pkg::gpc_status_t           status;
  logic [gpc_pkg::COUNT_W-1:0]    count;

  // input word fields
  assign cell_row     = in_tdata[2:0];
  assign cell_col     = in_tdata[5:3];
  assign cell_blocked = in_tdata[6];

  assign in_tready = !status.busy;
  assign in_fire   = in_tvalid && in_tready;
  assign in_store  = in_fire && (32'(cell_row) < MAX_ROWS) && (32'(cell_col) < MAX_COLS);

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= gpc_pkg::DIM_RESET;
      col_count_r <= gpc_pkg::DIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gpc_pkg::REG_ROW_COUNT: row_count_r <= cfg_data;
        gpc_pkg::REG_COL_COUNT: col_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the dimensions into 1..MAX and keep the last index
  always_comb begin
    if (row_count_r == '0) begin
      rows_last = '0;
    end else if (32'(row_count_r) > MAX_ROWS) begin
      rows_last = RW'(MAX_ROWS - 1);
    end else begin
      rows_last = RW'(row_count_r - gpc_pkg::CFG_DATA_W'(1));
    end
    if (col_count_r == '0) begin
      cols_last = '0;
    end else if (32'(col_count_r) > MAX_COLS) begin
      cols_last = CW'(MAX_COLS - 1);
    end else begin
      cols_last = CW'(col_count_r - gpc_pkg::CFG_DATA_W'(1));
    end
  end

  // grid store, one flop row per grid row
  always_ff @(posedge clk) begin
    if (in_store) begin
      blocked_rows_r[RW'(cell_row)][CW'(cell_col)] <= cell_blocked;
    end
  end

  // result register frees as soon as the receiver takes the word
  assign take = !out_valid_r || out_tready;

  gpc_count #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire && in_tlast),
    .take      (take),
    .rows_last (rows_last),
    .cols_last (cols_last),
    .row_bits  (blocked_rows_r[row_sel]),
    .row_sel   (row_sel),
    .status    (status),
    .count     (count)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (status.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) out_data_r <= count;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = gpc_pkg::OUT_DATA_W'(out_data_r);

endmodule
